>>> src/iecda_pkg.sv
// ----------------------------------------------------------------------------
// iecda_pkg
// Shared types and constants for the IEC direct address parser.
// ----------------------------------------------------------------------------
package iecda_pkg;

    // byte index accumulator width (8..32)
    localparam int INDEX_WIDTH = 16;
    localparam int BYTE_OUT_W  = 16;
    localparam int BYTE_EXT_W  = (INDEX_WIDTH > BYTE_OUT_W) ? INDEX_WIDTH : BYTE_OUT_W;
    // headroom for acc * 10 + 9
    localparam int BYTE_ACC_W  = INDEX_WIDTH + 4;

    // characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_Q       = 8'h51;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_L       = 8'h4C;

    localparam logic [3:0] BIT_MAX    = 4'd7;
    localparam logic [3:0] BIT_SAT    = 4'd8;
    localparam logic [3:0] BIT_NONE   = 4'hF;

    // size codes
    localparam logic [2:0] SIZE_X = 3'd0;
    localparam logic [2:0] SIZE_B = 3'd1;
    localparam logic [2:0] SIZE_W = 3'd2;
    localparam logic [2:0] SIZE_D = 3'd3;
    localparam logic [2:0] SIZE_L = 3'd4;

    localparam logic DIR_IN  = 1'b0;
    localparam logic DIR_OUT = 1'b1;

    typedef enum logic [6:0] {
        PH_PERCENT    = 7'b0000001,
        PH_DIR        = 7'b0000010,
        PH_SIZE       = 7'b0000100,
        PH_BYTE_FIRST = 7'b0001000,
        PH_BYTE_MORE  = 7'b0010000,
        PH_BIT_FIRST  = 7'b0100000,
        PH_BIT_MORE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic                         valid_res;
        logic                         direction;
        logic [2:0]                   size_code;
        logic [BYTE_OUT_W-1:0]        byte_addr;
        logic signed [3:0]            bit_pos;
    } t_result;

endpackage

>>> src/iecda_parser.sv
// ----------------------------------------------------------------------------
// iecda_parser
// Grammar state machine and index accumulators; one character per step.
// ----------------------------------------------------------------------------
module iecda_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char,
    output iecda_pkg::t_result  o_result
);
    import iecda_pkg::*;

    t_phase                   r_phase,      n_phase;
    logic                     r_err,        n_err;
    logic                     r_dir,        n_dir;
    logic [2:0]               r_size,       n_size;
    logic [INDEX_WIDTH-1:0]   r_byte_acc,   n_byte_acc;
    logic [3:0]               r_bit_acc,    n_bit_acc;
    logic                     r_bit_given,  n_bit_given;

    logic                     is_digit;
    logic [7:0]               upper;
    logic [3:0]               digit;
    logic [BYTE_ACC_W-1:0]    byte_sum;
    logic                     byte_ovf;
    logic [6:0]               bit_sum;
    logic                     bit_ovf;
    logic                     ok;
    logic [BYTE_EXT_W-1:0]    byte_ext;

    always_comb begin
        is_digit = (i_char inside {[8'h30:8'h39]});
        upper    = (i_char inside {[8'h61:8'h7A]}) ? (i_char - 8'h20) : i_char;
        digit    = i_char[3:0];
        // x10 as shift-add, then saturate at the index limit
        byte_sum = (BYTE_ACC_W'(r_byte_acc) << 3) + (BYTE_ACC_W'(r_byte_acc) << 1)
                   + BYTE_ACC_W'(digit);
        byte_ovf = (byte_sum > BYTE_ACC_W'({INDEX_WIDTH{1'b1}}));
        bit_sum  = (7'(r_bit_acc) << 3) + (7'(r_bit_acc) << 1) + 7'(digit);
        bit_ovf  = (bit_sum > 7'(BIT_MAX));
    end

    // result seen on a terminator
    always_comb begin
        ok       = !r_err && (r_phase == PH_BYTE_MORE || r_phase == PH_BIT_MORE);
        byte_ext = BYTE_EXT_W'(r_byte_acc);
        o_result = '0;
        if (ok) begin
            o_result.valid_res = 1'b1;
            o_result.direction = r_dir;
            o_result.size_code = r_size;
            o_result.byte_addr = byte_ext[BYTE_OUT_W-1:0];
            if (r_bit_given) begin
                o_result.bit_pos = r_bit_acc;
            end else if (r_size == SIZE_X) begin
                o_result.bit_pos = '0;
            end else begin
                o_result.bit_pos = BIT_NONE;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_err       = r_err;
        n_dir       = r_dir;
        n_size      = r_size;
        n_byte_acc  = r_byte_acc;
        n_bit_acc   = r_bit_acc;
        n_bit_given = r_bit_given;
        if (i_char == CH_NUL) begin
            n_phase     = PH_PERCENT;
            n_err       = 1'b0;
            n_dir       = DIR_IN;
            n_size      = SIZE_X;
            n_byte_acc  = '0;
            n_bit_acc   = '0;
            n_bit_given = 1'b0;
        end else if (!r_err) begin
            case (r_phase)
                PH_PERCENT: begin
                    if (i_char == CH_PERCENT) n_phase = PH_DIR;
                    else                      n_err   = 1'b1;
                end
                PH_DIR: begin
                    if (upper == CH_I) begin
                        n_dir   = DIR_IN;
                        n_phase = PH_SIZE;
                    end else if (upper == CH_Q) begin
                        n_dir   = DIR_OUT;
                        n_phase = PH_SIZE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_SIZE: begin
                    n_phase = PH_BYTE_FIRST;
                    case (upper)
                        CH_X:    n_size = SIZE_X;
                        CH_B:    n_size = SIZE_B;
                        CH_W:    n_size = SIZE_W;
                        CH_D:    n_size = SIZE_D;
                        CH_L:    n_size = SIZE_L;
                        default: n_err  = 1'b1;
                    endcase
                end
                PH_BYTE_FIRST, PH_BYTE_MORE: begin
                    if (is_digit) begin
                        n_phase    = PH_BYTE_MORE;
                        n_byte_acc = byte_ovf ? {INDEX_WIDTH{1'b1}}
                                              : byte_sum[INDEX_WIDTH-1:0];
                        if (byte_ovf) n_err = 1'b1;
                    end else if (r_phase == PH_BYTE_MORE && i_char == CH_DOT
                                 && r_size == SIZE_X) begin
                        n_bit_given = 1'b1;
                        n_phase     = PH_BIT_FIRST;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_BIT_FIRST, PH_BIT_MORE: begin
                    if (is_digit) begin
                        n_phase   = PH_BIT_MORE;
                        n_bit_acc = bit_ovf ? BIT_SAT : bit_sum[3:0];
                        if (bit_ovf) n_err = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PERCENT;
            r_err       <= 1'b0;
            r_dir       <= DIR_IN;
            r_size      <= SIZE_X;
            r_byte_acc  <= '0;
            r_bit_acc   <= '0;
            r_bit_given <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_dir       <= n_dir;
            r_size      <= n_size;
            r_byte_acc  <= n_byte_acc;
            r_bit_acc   <= n_bit_acc;
            r_bit_given <= n_bit_given;
        end
    end

endmodule

>>> src/iec_direct_address_parser_core.sv
// ----------------------------------------------------------------------------
// iec_direct_address_parser_core
// Character-serial parser for IEC 61131 direct addresses (%IX3.5, %QW12).
// ----------------------------------------------------------------------------
// Input channel: one ASCII character per word on i_char_code, handshake
// i_in_valid / o_in_stall. A zero character terminates the address.
// Output channel: one result word per terminator, handshake o_out_valid /
// i_out_stall, fields o_valid_res, o_direction, o_size_code, o_byte_addr,
// o_bit_pos. Non-terminator characters produce no output word.
// Pipeline: input register -> parse logic -> result register. A character
// is taken every cycle unless o_in_stall is high; a terminator's result
// goes through the input register and the result register to o_out_valid.
// Throughput: one character per cycle while o_in_stall is low, set by the
// state update (one times-ten accumulate and compare per character).
// Stall: while a result waits in the result register under i_out_stall,
// ordinary characters keep flowing; a second terminator holds in the input
// register and o_in_stall rises until the result word is taken.
// Reset (synchronous, active low): parser returns to expecting '%',
// both pipeline registers are emptied.
// Errors are sticky until the terminator; an errored address returns
// o_valid_res = 0 with all other fields zero.
// ----------------------------------------------------------------------------
module iec_direct_address_parser_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_char_code,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_valid_res,
    output logic                                o_direction,
    output logic [2:0]                          o_size_code,
    output logic [iecda_pkg::BYTE_OUT_W-1:0]    o_byte_addr,
    output logic signed [3:0]                   o_bit_pos
);
    import iecda_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    // result register
    logic        r_out_valid;
    t_result     r_out;

    t_result     step_result;
    logic        is_term;
    logic        slot_free;
    logic        proceed;
    logic        in_accept;

    // only a terminator needs the result slot
    assign is_term    = (r_in_char == CH_NUL);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign proceed    = r_in_valid && (!is_term || slot_free);
    assign o_in_stall = r_in_valid && !proceed;
    assign in_accept  = i_in_valid && !o_in_stall;

    iecda_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (proceed),
        .i_char   (r_in_char),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && is_term) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && is_term) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_out.valid_res;
    assign o_direction = r_out.direction;
    assign o_size_code = r_out.size_code;
    assign o_byte_addr = r_out.byte_addr;
    assign o_bit_pos   = r_out.bit_pos;

endmodule

>>> src/iecda_checker.sv
// ----------------------------------------------------------------------------
// iecda_checker
// Port-level checks for the IEC direct address parser, bound to the top.
// ----------------------------------------------------------------------------
module iecda_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_valid_res,
    input  logic                                o_direction,
    input  logic [2:0]                          o_size_code,
    input  logic [iecda_pkg::BYTE_OUT_W-1:0]    o_byte_addr,
    input  logic signed [3:0]                   o_bit_pos
);
    import iecda_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_addr))
        else $error("stalled result dropped or changed");

    // failed parse carries zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |->
            !o_direction && o_size_code == SIZE_X && o_byte_addr == '0
            && o_bit_pos == 4'sd0)
        else $error("invalid result with nonzero fields");

    // non-bit sizes report no bit, bit size reports 0..7
    a_bit_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |->
            (o_size_code == SIZE_X && !o_bit_pos[3])
            || ((o_size_code == SIZE_B || o_size_code == SIZE_W
                 || o_size_code == SIZE_D || o_size_code == SIZE_L)
                && o_bit_pos == BIT_NONE))
        else $error("bit index inconsistent with size");

    // the input side can never stall while the result slot is free
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result slot free");

endmodule

bind iec_direct_address_parser_core iecda_checker u_iecda_checker (.*);

>>> tb/iec_direct_address_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iec_direct_address_parser_core_tb
// Self-checking bench for the IEC direct address parser. Address strings go
// in one character word at a time. Some are well formed, some are broken and
// some are noise. A scoreboard parses the same characters and checks each
// result word field by field. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module iec_direct_address_parser_core_tb;

    import iecda_pkg::*;

    // run sizing
    localparam int NUM_CHARS   = 1700;   // random character words to send
    localparam int MAX_REPORTS = 10;     // mismatches printed in full
    localparam int IDLE_LIMIT  = 5000;   // watchdog: cycles with no handshake
    localparam int LONG_HOLD   = 400;    // receiver hold-off, in cycles
    localparam int DRAIN       = 16;     // settle time after the last result

    localparam longint unsigned BYTE_LIMIT = (64'd1 << INDEX_WIDTH) - 64'd1;

    // character helpers not in the package
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // receiver stall patterns
    localparam int STALL_NONE      = 0;
    localparam int STALL_LIGHT     = 1;
    localparam int STALL_HEAVY     = 2;
    localparam int STALL_ALTERNATE = 3;

    // ------------------------------------------------------------------------
    // Scoreboard: runs its own parser on every accepted character and keeps
    // the address results that the terminators should produce, oldest first.
    // ------------------------------------------------------------------------
    class addr_scoreboard;
        t_result          expected_addrs[$];
        int unsigned      mismatches;
        t_phase           ph;
        bit               err;
        logic             dir;
        logic [2:0]       size;
        longint unsigned  byte_acc;
        logic [3:0]       bit_acc;
        bit               bit_seen;

        function new();
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            ph       = PH_PERCENT;
            err      = 1'b0;
            dir      = DIR_IN;
            size     = SIZE_X;
            byte_acc = 0;
            bit_acc  = '0;
            bit_seen = 1'b0;
        endfunction

        function int pending();
            return expected_addrs.size();
        endfunction

        // one accepted character word
        function void parse_char(logic [7:0] c);
            logic [7:0]      u;
            t_result         r;
            longint unsigned acc;
            int unsigned     b;
            u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
            if (c == CH_NUL) begin
                // invalid results carry all-zero fields
                r = '0;
                if (!err && (ph == PH_BYTE_MORE || ph == PH_BIT_MORE)) begin
                    r.valid_res = 1'b1;
                    r.direction = dir;
                    r.size_code = size;
                    r.byte_addr = byte_acc[BYTE_OUT_W-1:0];
                    if (bit_seen)
                        r.bit_pos = bit_acc;
                    else
                        r.bit_pos = (size == SIZE_X) ? 4'd0 : BIT_NONE;
                end
                expected_addrs.push_back(r);
                clear_parse();
                return;
            end
            if (err)
                return;
            case (ph)
                PH_PERCENT: begin
                    if (c == CH_PERCENT) ph = PH_DIR; else err = 1'b1;
                end
                PH_DIR: begin
                    if (u == CH_I) begin
                        dir = DIR_IN;
                        ph  = PH_SIZE;
                    end else if (u == CH_Q) begin
                        dir = DIR_OUT;
                        ph  = PH_SIZE;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_SIZE: begin
                    ph = PH_BYTE_FIRST;
                    if (u == CH_X)      size = SIZE_X;
                    else if (u == CH_B) size = SIZE_B;
                    else if (u == CH_W) size = SIZE_W;
                    else if (u == CH_D) size = SIZE_D;
                    else if (u == CH_L) size = SIZE_L;
                    else                err  = 1'b1;
                end
                PH_BYTE_FIRST, PH_BYTE_MORE: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        // saturate on overflow, flag it
                        acc = byte_acc * 10 + longint'(c - CH_ZERO);
                        if (acc > BYTE_LIMIT) begin
                            err = 1'b1;
                            acc = BYTE_LIMIT;
                        end
                        byte_acc = acc;
                        ph = PH_BYTE_MORE;
                    end else if (ph == PH_BYTE_MORE && c == CH_DOT && size == SIZE_X) begin
                        bit_seen = 1'b1;
                        ph = PH_BIT_FIRST;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_BIT_FIRST, PH_BIT_MORE: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        b = bit_acc * 10 + (c - CH_ZERO);
                        if (b > BIT_MAX) begin
                            err = 1'b1;
                            b = 32'(BIT_SAT);
                        end
                        bit_acc = b[3:0];
                        ph = PH_BIT_MORE;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: err = 1'b1;
            endcase
        endfunction

        // one accepted result word
        function void check_word(t_result got);
            t_result want;
            if (expected_addrs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result word with none pending: ",
                              "valid=%0d dir=%0d size=%0d byte=%0d bit=%0d"},
                             $time, got.valid_res, got.direction, got.size_code,
                             got.byte_addr, got.bit_pos);
                return;
            end
            want = expected_addrs.pop_front();
            if (got.valid_res !== want.valid_res || got.direction !== want.direction ||
                got.size_code !== want.size_code || got.byte_addr !== want.byte_addr ||
                got.bit_pos !== want.bit_pos) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: address result differs", $time);
                    $display("  exp valid=%0d dir=%0d size=%0d byte=%0d bit=%0d",
                             want.valid_res, want.direction, want.size_code,
                             want.byte_addr, want.bit_pos);
                    $display("  got valid=%0d dir=%0d size=%0d byte=%0d bit=%0d",
                             got.valid_res, got.direction, got.size_code,
                             got.byte_addr, got.bit_pos);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic [7:0]             i_char_code  = 8'h00;
    logic                   i_out_stall  = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_valid_res;
    logic                   o_direction;
    logic [2:0]             o_size_code;
    logic [BYTE_OUT_W-1:0]  o_byte_addr;
    logic signed [3:0]      o_bit_pos;

    iec_direct_address_parser_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_valid_res  (o_valid_res),
        .o_direction  (o_direction),
        .o_size_code  (o_size_code),
        .o_byte_addr  (o_byte_addr),
        .o_bit_pos    (o_bit_pos)
    );

    addr_scoreboard sb;

    logic [7:0] addr_chars[$];   // string being built, terminator last
    int         chars_sent  = 0;
    int         burst_left  = 0;

    // receiver state
    int         words_taken = 0;
    int         hold_left   = 0;
    int         stall_mode  = STALL_NONE;
    int         mode_left   = 0;
    bit         stall_flip  = 1'b0;
    int         idle_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // drive one character word, hold it until taken, then let the
    // scoreboard parse it
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            // end of burst: random gap, often none
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.parse_char(c);
        chars_sent++;
    endtask

    task automatic send_address();
        addr_chars.push_back(CH_NUL);
        foreach (addr_chars[k]) send_char(addr_chars[k]);
        addr_chars.delete();
    endtask

    // stop offering until every pending result is back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic put(input logic [7:0] c);
        addr_chars.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put(s[k]);
    endtask

    // decimal digits, sometimes with leading zeros
    task automatic put_number(input int unsigned v);
        int zeros;
        zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) put(CH_ZERO);
        put_text($sformatf("%0d", v));
    endtask

    function automatic logic [7:0] any_case(input logic [7:0] c);
        return ($urandom_range(0, 1) != 0) ? (c | CASE_GAP) : c;
    endfunction

    function automatic logic [7:0] size_letter(input int k);
        case (k)
            0:       return CH_X;
            1:       return CH_B;
            2:       return CH_W;
            3:       return CH_D;
            default: return CH_L;
        endcase
    endfunction

    task automatic build_wellformed();
        logic [7:0]  size_ch;
        int          pick;
        int unsigned addr_num;
        put(CH_PERCENT);
        put(any_case(($urandom_range(0, 1) != 0) ? CH_Q : CH_I));
        size_ch = size_letter($urandom_range(0, 4));
        put(any_case(size_ch));
        // mostly small indexes, some near and past the top of the range
        pick = $urandom_range(0, 9);
        if (pick < 6)      addr_num = $urandom_range(0, 99);
        else if (pick < 8) addr_num = $urandom_range(0, 65535);
        else if (pick < 9) addr_num = $urandom_range(65530, 65545);
        else               addr_num = $urandom_range(0, 999999);
        put_number(addr_num);
        if (size_ch == CH_X && $urandom_range(0, 9) < 7) begin
            put(CH_DOT);
            pick = $urandom_range(0, 9);
            if (pick < 7)      put_number($urandom_range(0, 7));
            else if (pick < 9) put_number($urandom_range(8, 9));
            else               put_number($urandom_range(10, 99));
        end
    endtask

    // well-formed string with one defect
    task automatic build_broken();
        int n;
        build_wellformed();
        case ($urandom_range(0, 4))
            0: begin
                // cut short, possibly down to nothing
                n = $urandom_range(1, addr_chars.size());
                repeat (n) void'(addr_chars.pop_back());
            end
            1: addr_chars.insert($urandom_range(0, addr_chars.size()),
                                 8'($urandom_range(1, 255)));
            2: addr_chars[$urandom_range(0, addr_chars.size() - 1)] =
                   8'($urandom_range(1, 255));
            3: begin
                // bit part on any size
                put(CH_DOT);
                put(8'(CH_ZERO + $urandom_range(0, 7)));
            end
            default: put(CH_DOT);
        endcase
    endtask

    task automatic build_noise();
        if ($urandom_range(0, 1) != 0) put(CH_PERCENT);
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(1, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  pick;
        bit  mid_pause_done;
        mid_pause_done = 1'b0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty string, valid bit with leading zero, byte
        // overflow, bit part on a byte address
        send_address();
        put_text("%QX0.07");
        send_address();
        put_text("%iw65536");
        send_address();
        put_text("%IB1.0");
        send_address();
        wait_all_results();

        chars_sent = 0;
        while (chars_sent < NUM_CHARS) begin
            if (!mid_pause_done && chars_sent >= NUM_CHARS / 2) begin
                mid_pause_done = 1'b1;
                wait_all_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)      build_wellformed();
            else if (pick < 85) build_broken();
            else                build_noise();
            send_address();
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("iec_direct_address_parser_core: match");
        else
            $display("iec_direct_address_parser_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: takes result words, checks them, picks the next stall.
    // Twice it holds off for a long stretch so the parser backs up and
    // stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.valid_res = o_valid_res;
            got.direction = o_direction;
            got.size_code = o_size_code;
            got.byte_addr = o_byte_addr;
            got.bit_pos   = o_bit_pos;
            sb.check_word(got);
            words_taken++;
            if (words_taken == 30 || words_taken == 120)
                hold_left = LONG_HOLD;
        end

        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(STALL_NONE, STALL_ALTERNATE);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            stall_flip = ~stall_flip;
            case (stall_mode)
                STALL_LIGHT:     i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:     i_out_stall <= ($urandom_range(0, 9) < 7);
                STALL_ALTERNATE: i_out_stall <= stall_flip;
                default:         i_out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no word moving on either side ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("iec_direct_address_parser_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
